@@ rtl/core/tla_pkg.sv @@
// Package for the topological level assignment block.
// Holds the beat types, configuration register indexes and default sizes.
// No dependencies.
package tla_pkg;

   localparam int DefMaxNodes = 64;
   localparam int DefMaxDeps  = 16;

   localparam logic [6:0] NODE_COUNT_RESET = 7'd64;
   localparam logic [7:0] FIRST_LEVEL_RESET = 8'd0;

   localparam logic CSR_NODE_COUNT  = 1'b0;
   localparam logic CSR_FIRST_LEVEL = 1'b1;

   typedef struct packed {
      logic [5:0] pkg_index;
      logic [5:0] dep_index;
      logic       edge_valid;
      logic       last_item;
   } tla_req_type;

   typedef struct packed {
      logic [5:0] out_pkg;
      logic [8:0] pkg_level;
      logic       resolved;
      logic [8:0] final_level;
      logic       overflow;
      logic       last_result;
   } tla_rsp_type;

endpackage

@@ rtl/core/tla_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/core/topological_level_assign.sv @@
// Top level of the topological level assignment block.
// Uses tla_pkg and two tla_ram instances (dependency lists, per-package state).
//
// Usage: drive req with start while busy is low; each accepted beat may load
// one dependency edge (pkg_index depends on dep_index). A beat with
// last_item set loads its edge first and then computes levels in rounds.
// Loading an edge reads and then writes the package's state entry; a beat
// without an edge and without last_item leaves the block idle. The compute
// starts with a setup state, then walks the packages once per round to
// resolve them and, if any resolved, once more to count down each pending
// package over its dependency list; both walks are bounded by the single
// read port of each RAM. Results then stream out, one per cycle on rsp_valid,
// for packages 0 up to node_count-1 (node_count clamped to 1..MAX_NODES) in
// ascending order, with last_result on the final beat; the receiver cannot
// stall them. After the last result the per-package state is invalidated at
// once and busy drops. Configuration is taken on csr_we at any edge, meant
// for idle time. Synchronous reset clears the FSM state, rsp_valid, the
// configuration and the per-package valid bits; no clearing pass is needed.
module topological_level_assign
   import tla_pkg::*;
#(
   parameter int MAX_NODES = DefMaxNodes,
   parameter int MAX_DEPS  = DefMaxDeps
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tla_req_type req,
   output logic        rsp_valid,
   output tla_rsp_type rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_DEPS + 1);
   localparam int LAW = $clog2(MAX_NODES * MAX_DEPS);
   localparam int NEW = 2 * CW + 11;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_LD_WR  = 12'b000000000010,
      S_RA_RD  = 12'b000000000100,
      S_RA_CHK = 12'b000000001000,
      S_RB_RD  = 12'b000000010000,
      S_RB_CHK = 12'b000000100000,
      S_LS_RD  = 12'b000001000000,
      S_LS_CHK = 12'b000010000000,
      S_RB_WR  = 12'b000100000000,
      S_EM     = 12'b001000000000,
      S_EM_END = 12'b010000000000,
      S_START  = 12'b100000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [NW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [CW-1:0]   hits_ff, hits_in;
   logic [8:0]      level_ff, level_in;
   logic            any_ff, any_in;
   logic [MAX_NODES-1:0] now_ff, now_in;
   logic [MAX_NODES-1:0] vld_ff, vld_in;
   logic            vld_rd_ff;
   logic            pend_ff, pend_in;
   logic [NW-1:0]   out_idx_ff, out_idx_in;
   tla_req_type     req_ff, req_in;
   logic [NEW-1:0]  ent_ff, ent_in;
   logic [6:0]      node_count_ff;
   logic [7:0]      first_level_ff;

   logic [6:0]      n_eff;
   logic [NW-1:0]   last_idx;
   logic            edge_ok;

   logic            n_we;
   logic [NW-1:0]   n_waddr, n_raddr;
   logic [NEW-1:0]  n_wdata, n_rdata, ent;
   logic            l_we;
   logic [LAW-1:0]  l_waddr, l_raddr;
   logic [5:0]      l_wdata, l_rdata;

   logic [CW-1:0]   e_cnt, e_rem, f_cnt, f_rem;
   logic            e_done, e_ovf, f_done, f_ovf;
   logic [8:0]      e_lvl, f_lvl;
   logic            dep_hit;

   tla_ram #(.WIDTH(NEW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .raddr(n_raddr), .rdata(n_rdata)
   );

   tla_ram #(.WIDTH(6), .DEPTH(MAX_NODES * MAX_DEPS)) u_list_ram (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rdata)
   );

   always_comb begin
      if (node_count_ff == 7'd0) begin
         n_eff = 7'd1;
      end else if (node_count_ff > 7'(MAX_NODES)) begin
         n_eff = 7'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign last_idx = NW'(n_eff - 7'd1);
   assign edge_ok  = req.edge_valid && (7'(req.pkg_index) < 7'(MAX_NODES));

   assign ent    = vld_rd_ff ? n_rdata : '0;
   assign e_cnt  = ent[CW-1:0];
   assign e_rem  = ent[2*CW-1:CW];
   assign e_done = ent[2*CW];
   assign e_lvl  = ent[2*CW+9:2*CW+1];
   assign e_ovf  = ent[2*CW+10];
   assign f_cnt  = ent_ff[CW-1:0];
   assign f_rem  = ent_ff[2*CW-1:CW];
   assign f_done = ent_ff[2*CW];
   assign f_lvl  = ent_ff[2*CW+9:2*CW+1];
   assign f_ovf  = ent_ff[2*CW+10];

   assign dep_hit = (7'(l_rdata) < n_eff) && now_ff[l_rdata[NW-1:0]];

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      j_in       = j_ff;
      hits_in    = hits_ff;
      level_in   = level_ff;
      any_in     = any_ff;
      now_in     = now_ff;
      vld_in     = vld_ff;
      pend_in    = 1'b0;
      out_idx_in = out_idx_ff;
      req_in     = req_ff;
      ent_in     = ent_ff;
      n_we       = 1'b0;
      n_waddr    = idx_ff;
      n_wdata    = '0;
      n_raddr    = idx_ff;
      l_we       = 1'b0;
      l_waddr    = LAW'(req_ff.pkg_index[NW-1:0]) * LAW'(MAX_DEPS) + LAW'(e_cnt);
      l_wdata    = req_ff.dep_index;
      l_raddr    = LAW'(idx_ff) * LAW'(MAX_DEPS) + LAW'(j_ff);

      unique case (state_ff)
         S_IDLE: begin
            n_raddr = req.pkg_index[NW-1:0];
            if (start) begin
               req_in = req;
               if (edge_ok) begin
                  state_in = S_LD_WR;
               end else if (req.last_item) begin
                  state_in = S_START;
               end
            end
         end
         S_LD_WR: begin
            n_we    = 1'b1;
            n_waddr = req_ff.pkg_index[NW-1:0];
            vld_in[req_ff.pkg_index[NW-1:0]] = 1'b1;
            if (e_cnt >= CW'(MAX_DEPS)) begin
               n_wdata = {1'b1, e_lvl, e_done, e_rem, e_cnt};
            end else begin
               l_we    = 1'b1;
               n_wdata = {e_ovf, e_lvl, e_done, e_cnt + CW'(1), e_cnt + CW'(1)};
            end
            state_in = req_ff.last_item ? S_START : S_IDLE;
         end
         S_START: begin
            level_in = 9'(first_level_ff);
            idx_in   = '0;
            any_in   = 1'b0;
            now_in   = '0;
            state_in = S_RA_RD;
         end
         S_RA_RD: begin
            state_in = S_RA_CHK;
         end
         S_RA_CHK: begin
            if (!e_done && e_rem == '0) begin
               n_we           = 1'b1;
               vld_in[idx_ff] = 1'b1;
               n_wdata        = {e_ovf, level_ff, 1'b1, e_rem, e_cnt};
               now_in[idx_ff] = 1'b1;
               any_in         = 1'b1;
            end
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               state_in = any_in ? S_RB_RD : S_EM;
            end else begin
               idx_in   = idx_ff + NW'(1);
               state_in = S_RA_RD;
            end
         end
         S_RB_RD: begin
            state_in = S_RB_CHK;
         end
         S_RB_CHK: begin
            ent_in  = ent;
            j_in    = '0;
            hits_in = '0;
            if (e_done) begin
               if (idx_ff == last_idx) begin
                  idx_in   = '0;
                  level_in = level_ff + 9'd1;
                  any_in   = 1'b0;
                  now_in   = '0;
                  state_in = S_RA_RD;
               end else begin
                  idx_in   = idx_ff + NW'(1);
                  state_in = S_RB_RD;
               end
            end else if (e_cnt == '0) begin
               state_in = S_RB_WR;
            end else begin
               state_in = S_LS_RD;
            end
         end
         S_LS_RD: begin
            state_in = S_LS_CHK;
         end
         S_LS_CHK: begin
            if (dep_hit) begin
               hits_in = hits_ff + CW'(1);
            end
            j_in = j_ff + CW'(1);
            state_in = (j_in == f_cnt) ? S_RB_WR : S_LS_RD;
         end
         S_RB_WR: begin
            n_we           = 1'b1;
            vld_in[idx_ff] = 1'b1;
            n_wdata        = {f_ovf, f_lvl, f_done,
                              (hits_ff >= f_rem) ? CW'(0) : f_rem - hits_ff, f_cnt};
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               level_in = level_ff + 9'd1;
               any_in   = 1'b0;
               now_in   = '0;
               state_in = S_RA_RD;
            end else begin
               idx_in   = idx_ff + NW'(1);
               state_in = S_RB_RD;
            end
         end
         S_EM: begin
            pend_in    = 1'b1;
            out_idx_in = idx_ff;
            if (idx_ff == last_idx) begin
               state_in = S_EM_END;
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         S_EM_END: begin
            vld_in   = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         vld_ff         <= '0;
         pend_ff        <= 1'b0;
         node_count_ff  <= NODE_COUNT_RESET;
         first_level_ff <= FIRST_LEVEL_RESET;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         pend_ff  <= pend_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NODE_COUNT:  node_count_ff  <= csr_wdata[6:0];
               CSR_FIRST_LEVEL: first_level_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      j_ff       <= j_in;
      hits_ff    <= hits_in;
      level_ff   <= level_in;
      any_ff     <= any_in;
      now_ff     <= now_in;
      out_idx_ff <= out_idx_in;
      req_ff     <= req_in;
      ent_ff     <= ent_in;
      vld_rd_ff  <= vld_ff[n_raddr];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = pend_ff;

   always_comb begin
      rsp.out_pkg     = 6'(out_idx_ff);
      rsp.pkg_level   = e_done ? e_lvl : 9'd0;
      rsp.resolved    = e_done;
      rsp.final_level = level_ff;
      rsp.overflow    = e_ovf;
      rsp.last_result = (out_idx_ff == last_idx);
   end

endmodule

@@ rtl/core/tla_checker.sv @@
// Port-level checker for topological_level_assign, bound to the top level.
// Uses tla_pkg.
module tla_assertions
   import tla_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input tla_rsp_type rsp
);

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");

   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last_result |=> rsp_valid)
      else $error("gap in result burst");

   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last_result |=> !rsp_valid)
      else $error("beat after last result");

   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last_result |=> rsp.out_pkg == $past(rsp.out_pkg) + 6'd1)
      else $error("results out of order");

   a_rsp_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.resolved |-> rsp.pkg_level == 9'd0)
      else $error("level on unresolved package");

endmodule

bind topological_level_assign tla_assertions u_tla_assertions (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp(rsp)
);

@@ tb/tla_checker.sv @@
// Checker for topological_level_assign: watches the request, result and CSR ports.
// Keeps its own copy of the edge tables and predicts the levels of each set.
// Depends on tla_pkg.
module tla_checker
   import tla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  tla_req_type req,
   input  logic        rsp_valid,
   input  tla_rsp_type rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          levels_pending,
   output int          results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [5:0] edge_list [64][16];
   logic [4:0] edge_cnt [64];
   logic [4:0] left_cnt [64];
   logic       resolved_flag [64];
   logic [8:0] level_of [64];
   logic       dropped_flag [64];
   logic [6:0] nodes_reg;
   logic [7:0] base_level;
   tla_rsp_type level_queue [$];

   assign levels_pending = level_queue.size();

   task automatic clear_graph();
      for (int i = 0; i < 64; i++) begin
         edge_cnt[i] = '0;
         left_cnt[i] = '0;
         resolved_flag[i] = 1'b0;
         level_of[i] = '0;
         dropped_flag[i] = 1'b0;
      end
   endtask

   task automatic add_edge(logic [5:0] owner, logic [5:0] target);
      if (edge_cnt[owner] >= 16) begin
         dropped_flag[owner] = 1'b1;
      end else begin
         edge_list[owner][edge_cnt[owner]] = target;
         edge_cnt[owner] = edge_cnt[owner] + 1;
         left_cnt[owner] = edge_cnt[owner];
      end
   endtask

   task automatic assign_levels();
      int n;
      int lvl;
      int hits;
      bit any;
      bit fresh [64];
      tla_rsp_type r;
      n = nodes_reg;
      if (n == 0) n = 1;
      if (n > 64) n = 64;
      lvl = base_level;
      forever begin
         any = 0;
         for (int i = 0; i < n; i++) begin
            fresh[i] = !resolved_flag[i] && left_cnt[i] == 0;
            if (fresh[i]) begin
               any = 1;
               resolved_flag[i] = 1'b1;
               level_of[i] = lvl[8:0];
            end
         end
         if (!any) break;
         for (int i = 0; i < n; i++) begin
            if (resolved_flag[i]) continue;
            hits = 0;
            for (int j = 0; j < edge_cnt[i]; j++)
               if (edge_list[i][j] < n && fresh[edge_list[i][j]]) hits++;
            if (hits >= left_cnt[i]) left_cnt[i] = '0;
            else left_cnt[i] = left_cnt[i] - hits;
         end
         lvl++;
      end
      for (int i = 0; i < n; i++) begin
         r.out_pkg     = i[5:0];
         r.pkg_level   = resolved_flag[i] ? level_of[i] : 9'd0;
         r.resolved    = resolved_flag[i];
         r.final_level = lvl[8:0];
         r.overflow    = dropped_flag[i];
         r.last_result = (i == n - 1);
         level_queue.push_back(r);
      end
      clear_graph();
   endtask

   always @(posedge clock) begin
      tla_rsp_type want;
      if (reset) begin
         clear_graph();
         nodes_reg = NODE_COUNT_RESET;
         base_level = FIRST_LEVEL_RESET;
         level_queue.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (level_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %p", rsp);
            end else begin
               want = level_queue.pop_front();
               if (rsp !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("mismatch: expected %p got %p", want, rsp);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_NODE_COUNT) nodes_reg = csr_wdata[6:0];
            else base_level = csr_wdata;
         end
         if (start && !busy) begin
            if (req.edge_valid) add_edge(req.pkg_index, req.dep_index);
            if (req.last_item) assign_levels();
         end
      end
   end

endmodule

@@ tb/testbench.sv @@
// Top of the topological_level_assign testbench: clock, reset, stimulus and verdict.
// Depends on tla_pkg, topological_level_assign and tla_checker.
module testbench;
   import tla_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   tla_req_type req = '0;
   logic        rsp_valid;
   tla_rsp_type rsp;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;
   int          fail_count;
   int          levels_pending;
   int          results_seen;
   int          beats_sent = 0;
   int          sets_sent = 0;
   int          idle_pct = 0;
   int          cur_nodes = 64;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   topological_level_assign dut (
      .clock, .reset, .start, .busy, .req, .rsp_valid, .rsp,
      .csr_we, .csr_index, .csr_wdata
   );

   tla_checker u_checker (
      .clock, .reset, .start, .busy, .req, .rsp_valid, .rsp,
      .csr_we, .csr_index, .csr_wdata,
      .fail_count, .levels_pending, .results_seen
   );

   initial begin
      #50ms;
      $display("FAIL topological_level_assign");
      $finish;
   end

   task automatic send_beat(int pkg, int dep, bit valid, bit last);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req <= '{pkg_index: pkg[5:0], dep_index: dep[5:0], edge_valid: valid, last_item: last};
      do @(posedge clock); while (busy);
      beats_sent++;
      if (last) sets_sent++;
   endtask

   // hold until every result is in and the block is idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (levels_pending != 0);
      repeat (6) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_cfg(int nodes, int first);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= nodes[7:0];
      @(posedge clock);
      csr_index <= CSR_FIRST_LEVEL;
      csr_wdata <= first[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_nodes = nodes[6:0] == 0 ? 1 : (nodes[6:0] > 64 ? 64 : nodes[6:0]);
   endtask

   task automatic random_set();
      int len;
      int kind;
      int p;
      int d;
      bit v;
      len = $urandom_range(12, 1);
      kind = $urandom_range(9);
      for (int k = 0; k < len; k++) begin
         v = 1'b1;
         if (kind == 0) begin
            p = $urandom_range(63);
            d = $urandom_range(63);
            v = $urandom_range(1);
         end else if (kind == 1) begin
            p = $urandom_range(cur_nodes > 2 ? 1 : 0);
            d = $urandom_range(cur_nodes - 1);
         end else begin
            p = $urandom_range(cur_nodes - 1);
            d = p == 0 ? 0 : $urandom_range(p - 1);
            if ($urandom_range(15) == 0) d = $urandom_range(cur_nodes - 1);
            if ($urandom_range(15) == 0) v = 1'b0;
         end
         send_beat(p, d, v, k == len - 1);
      end
   endtask

   initial begin
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty graph at reset settings
      send_beat(63, 63, 1'b0, 1'b1);
      drain();
      send_beat(63, 63, 1'b1, 1'b1);
      write_cfg(4, 255);
      send_beat(1, 0, 1'b1, 1'b0);
      send_beat(3, 3, 1'b1, 1'b0);
      send_beat(2, 1, 1'b1, 1'b1);
      write_cfg(2, 7);
      for (int k = 0; k < 17; k++) send_beat(0, 1, 1'b1, 1'b0);
      send_beat(1, 0, 1'b1, 1'b1);
      send_beat(1, 5, 1'b1, 1'b0);
      send_beat(40, 0, 1'b1, 1'b1);
      write_cfg(0, 1);
      send_beat(0, 0, 1'b0, 1'b1);
      write_cfg(255, 128);
      for (int k = 1; k < 64; k++) send_beat(k, k - 1, 1'b1, k == 63);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 46;
            2: idle_pct = 46;
            default: idle_pct = 38;
         endcase
         while (beats_sent < 40 + (ph + 1) * 108) begin
            if ($urandom_range(3) == 0) begin
               pick = $urandom_range(9);
               write_cfg(pick == 0 ? 64 : (pick == 1 ? 1 : $urandom_range(16, 2)),
                         pick == 2 ? 255 : $urandom_range(255));
            end else if ($urandom_range(7) == 0) begin
               drain();
            end
            random_set();
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d request beats in %0d graphs, %0d level results checked",
               beats_sent, sets_sent, results_seen);
      if (fail_count == 0) begin
         $display("PASS topological_level_assign");
      end else begin
         $display("FAIL topological_level_assign");
      end
      $finish;
   end

endmodule
